### src/pbosc_pkg.sv
// Package for the polyBLEP sine/saw oscillator: tables, constants and the
// command and status types shared by the sequencer and the divider.
// No dependencies.
`default_nettype none

package pbosc_pkg;

   localparam int STEP_W = 6;
   localparam int DIV_W = 32;

   localparam logic [1:0] CSR_COARSE = 2'd0;
   localparam logic [1:0] CSR_FINE   = 2'd1;
   localparam logic [1:0] CSR_MIX    = 2'd2;
   localparam logic [1:0] CSR_FS     = 2'd3;

   localparam logic [24:0] C4_Q16     = 25'd17146184;
   localparam logic [17:0] FS_MIN     = 18'd8000;
   localparam logic [17:0] FS_RESET   = 18'd48000;
   localparam logic [12:0] MIX_MAX    = 13'd4096;
   localparam logic [33:0] F_LO       = 34'd1310720;
   localparam logic [11:0] SMOOTH_Q16 = 12'd3277;

   localparam logic [17:0] EXP2_TAB [0:16] = '{
      18'd65536, 18'd68438, 18'd71468, 18'd74632, 18'd77936, 18'd81386,
      18'd84990, 18'd88752, 18'd92682, 18'd96785, 18'd101070, 18'd105545,
      18'd110218, 18'd115098, 18'd120194, 18'd125515, 18'd131072
   };

   localparam logic [14:0] QSINE_TAB [0:32] = '{
      15'd0, 15'd804, 15'd1606, 15'd2404, 15'd3196, 15'd3981, 15'd4756,
      15'd5520, 15'd6270, 15'd7005, 15'd7723, 15'd8423, 15'd9102, 15'd9760,
      15'd10394, 15'd11003, 15'd11585, 15'd12140, 15'd12665, 15'd13160,
      15'd13623, 15'd14053, 15'd14449, 15'd14811, 15'd15137, 15'd15426,
      15'd15679, 15'd15893, 15'd16069, 15'd16207, 15'd16305, 15'd16364,
      15'd16384
   };

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

`default_nettype wire

### src/pbosc_div.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
// Uses pbosc_pkg for the command and status types.
`default_nettype none

module pbosc_div #(
   parameter int QW = 32
) (
   input  wire                          clock,
   input  wire                          reset,
   input  pbosc_pkg::div_cmd_type       cmd,
   input  wire [pbosc_pkg::DIV_W-1:0]   rem_init,
   input  wire [QW-1:0]                 low_init,
   input  wire [pbosc_pkg::DIV_W-1:0]   divisor,
   output pbosc_pkg::div_sts_type       sts,
   output logic [QW-1:0]                quot
);

   logic [pbosc_pkg::DIV_W-1:0]  rem_ff, rem_in;
   logic [pbosc_pkg::DIV_W-1:0]  dvs_ff;
   logic [QW-1:0]                q_ff, q_in;
   logic [pbosc_pkg::STEP_W-1:0] cnt_ff;
   logic                         busy_ff, done_ff;
   logic [pbosc_pkg::DIV_W:0]    trial;
   logic                         fits;

   always_comb begin
      trial = {rem_ff, q_ff[QW-1]};
      fits = trial >= {1'b0, dvs_ff};
      rem_in = fits ? pbosc_pkg::DIV_W'(trial - {1'b0, dvs_ff})
                    : pbosc_pkg::DIV_W'(trial);
      q_in = {q_ff[QW-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff <= cmd.steps;
            rem_ff <= rem_init;
            q_ff <= low_init;
            dvs_ff <= divisor;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            q_ff <= q_in;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == pbosc_pkg::STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quot = q_ff;

endmodule

`default_nettype wire

### src/polyblep_sine_saw_oscillator.sv
// Top level of the polyBLEP sine/saw oscillator: register file, sequencer
// and datapath. Uses pbosc_pkg and the pbosc_div divider.
//
// Usage: one transfer on the req_ channel carries one pitch control voltage
// per audio sample; one transfer on the rsp_ channel returns the sample.
// Registers are written on the csr_ channel (always ready); the user must
// write them only while idle, as the block itself does not enforce this.
// The shared divider computes PHASE_BITS quotient bits for the phase
// increment and 16 for the polyBLEP correction, which is divided only when
// it is needed, with the sequencer steps around them.
// req_tready is high only while the sequencer is idle, so a new item is
// accepted only once the sequencer is through with the previous one. The
// result sits in an output register, so a new item may be accepted while it
// waits; a stalled receiver holds the sequencer at its last step until the
// previous result is taken.
// Reset clears the registers to their defaults, the phase to zero and the
// smoothed frequency to middle C, and empties the output register.
`default_nettype none

module polyblep_sine_saw_oscillator #(
   parameter int PHASE_BITS = 32,
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,   // [16:0] pitch_cv
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] audio_out
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [17:0] csr_data
);

   localparam int LD = $clog2(SINE_TABLE_DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE, ST_EXP, ST_MUL, ST_SHIFT, ST_SMUL, ST_SUPD, ST_DIVI, ST_WINC,
      ST_BLEP, ST_WBLEP, ST_SQ, ST_BLEPV, ST_SINE, ST_MIX, ST_OUT
   } state_type;

   state_type state_ff;
   logic signed [15:0] coarse_ff;
   logic signed [12:0] fine_ff;
   logic [12:0] mix_ff;
   logic [17:0] fs_ff;
   logic [PHASE_BITS-1:0] phase_ff, inc_ff;
   logic [33:0] s_ff, f_ff;
   logic [16:0] poff_ff;
   logic [17:0] m_ff;
   logic [26:0] fb_ff;
   logic signed [46:0] dp_ff;
   logic [15:0] x_ff;
   logic [31:0] sq_ff;
   logic neg_ff;
   logic signed [17:0] blep_ff, sine_ff;
   logic signed [33:0] mixp_ff;
   logic [15:0] rsp_data_ff;
   logic rsp_valid_ff;

   pbosc_pkg::div_cmd_type div_cmd;
   pbosc_pkg::div_sts_type div_sts;
   logic [pbosc_pkg::DIV_W-1:0] div_rem, div_dvs;
   logic [PHASE_BITS-1:0] div_low, div_q;

   logic [17:0] fs_eff;
   logic [12:0] mix_eff;
   logic signed [18:0] p_sum;
   logic [16:0] poff_in;
   logic [3:0] eidx;
   logic [17:0] ediff;
   logic [4:0] oct;
   logic [34:0] fsh;
   logic [33:0] f_hi;
   logic signed [34:0] dlt;
   logic signed [47:0] s_next;
   logic [31:0] t, dt;
   logic [32:0] tsum;
   logic [14:0] pos;
   logic [13:0] wq;
   logic [5:0] seg;
   logic [14:0] qa, qb, qv;
   logic signed [17:0] sine_in;
   logic signed [18:0] blep_in;
   logic signed [19:0] saw, diff;
   logic signed [21:0] mixed;
   logic signed [24:0] vol5;
   logic signed [20:0] volts;
   logic [15:0] out_in;

   always_comb begin
      fs_eff = (fs_ff < pbosc_pkg::FS_MIN) ? pbosc_pkg::FS_MIN : fs_ff;
      mix_eff = (mix_ff > pbosc_pkg::MIX_MAX) ? pbosc_pkg::MIX_MAX : mix_ff;

      p_sum = 19'($signed(req_tdata[16:0])) + 19'(coarse_ff) + 19'(fine_ff);
      if (p_sum < -19'sd32768) begin
         poff_in = 17'd0;
      end else if (p_sum > 19'sd36864) begin
         poff_in = 17'd69632;
      end else begin
         poff_in = 17'(p_sum + 19'sd32768);
      end

      eidx = poff_ff[11:8];
      ediff = pbosc_pkg::EXP2_TAB[5'(eidx) + 5'd1] - pbosc_pkg::EXP2_TAB[eidx];

      oct = poff_ff[16:12];
      if (oct >= 5'd8) begin
         fsh = 35'(fb_ff) << (oct - 5'd8);
      end else begin
         fsh = 35'(fb_ff) >> (5'd8 - oct);
      end
      f_hi = 34'(fs_eff) << 15;

      dlt = $signed({1'b0, f_ff}) - $signed({1'b0, s_ff});
      s_next = $signed({14'b0, s_ff}) + 48'(dp_ff >>> 16);

      t = 32'({phase_ff, 32'b0} >> PHASE_BITS);
      dt = 32'({inc_ff, 32'b0} >> PHASE_BITS);
      tsum = {1'b0, t} + {1'b0, dt};

      pos = 15'(phase_ff[PHASE_BITS-1 -: LD]) << (15 - LD);
      wq = pos[13] ? 14'd8192 - {1'b0, pos[12:0]} : {1'b0, pos[12:0]};
      seg = wq[13:8];
      qa = pbosc_pkg::QSINE_TAB[seg];
      qb = pbosc_pkg::QSINE_TAB[(seg >= 6'd32) ? seg : seg + 6'd1];
      if (seg >= 6'd32) begin
         qv = pbosc_pkg::QSINE_TAB[32];
      end else begin
         qv = qa + 15'(((23'(qb - qa)) * 23'(wq[7:0])) >> 8);
      end
      sine_in = pos[14] ? -$signed({1'b0, qv, 2'b0}) : $signed({1'b0, qv, 2'b0});

      if (neg_ff) begin
         blep_in = $signed({3'b0, sq_ff[31:16]}) - $signed({2'b0, x_ff, 1'b0})
                   + 19'sd65536;
      end else begin
         blep_in = $signed({2'b0, x_ff, 1'b0}) - $signed({3'b0, sq_ff[31:16]})
                   - 19'sd65536;
      end

      saw = $signed({3'b0, t[31:15]}) - 20'sd65536 - 20'(blep_ff);
      diff = saw - 20'(sine_ff);

      mixed = 22'(sine_ff) + 22'(mixp_ff >>> 12);
      vol5 = 25'(mixed) * 25'sd5;
      volts = 21'(vol5 >>> 4);
      if (volts > 21'sd20480) begin
         out_in = 16'd20480;
      end else if (volts < -21'sd20480) begin
         out_in = 16'(-21'sd20480);
      end else begin
         out_in = 16'(volts);
      end
   end

   always_comb begin
      div_cmd.start = 1'b0;
      div_cmd.steps = pbosc_pkg::STEP_W'(PHASE_BITS);
      div_rem = 32'(s_ff >> 16);
      div_low = PHASE_BITS'(s_ff[15:0]) << (PHASE_BITS - 16);
      div_dvs = 32'(fs_eff);
      if (state_ff == ST_DIVI) begin
         div_cmd.start = 1'b1;
      end else if (state_ff == ST_BLEP) begin
         div_cmd.steps = pbosc_pkg::STEP_W'(16);
         div_low = '0;
         div_dvs = dt;
         div_rem = t;
         if (t >= dt) begin
            div_rem = 32'(33'h1_0000_0000 - {1'b0, t});
         end
         div_cmd.start = (dt != 32'd0) && ((t < dt) || (tsum > 33'h1_0000_0000));
      end
   end

   pbosc_div #(.QW(PHASE_BITS)) u_div (
      .clock(clock),
      .reset(reset),
      .cmd(div_cmd),
      .rem_init(div_rem),
      .low_init(div_low),
      .divisor(div_dvs),
      .sts(div_sts),
      .quot(div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         coarse_ff <= '0;
         fine_ff <= '0;
         mix_ff <= '0;
         fs_ff <= pbosc_pkg::FS_RESET;
         phase_ff <= '0;
         s_ff <= 34'(pbosc_pkg::C4_Q16);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            unique case (csr_index)
               pbosc_pkg::CSR_COARSE: coarse_ff <= $signed(csr_data[15:0]);
               pbosc_pkg::CSR_FINE:   fine_ff <= $signed(csr_data[12:0]);
               pbosc_pkg::CSR_MIX:    mix_ff <= csr_data[12:0];
               pbosc_pkg::CSR_FS:     fs_ff <= csr_data;
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  poff_ff <= poff_in;
                  state_ff <= ST_EXP;
               end
            end
            ST_EXP: begin
               m_ff <= pbosc_pkg::EXP2_TAB[eidx]
                       + 18'((26'(ediff) * 26'(poff_ff[7:0])) >> 8);
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               fb_ff <= 27'((43'(pbosc_pkg::C4_Q16) * 43'(m_ff)) >> 16);
               state_ff <= ST_SHIFT;
            end
            ST_SHIFT: begin
               if (fsh < 35'(pbosc_pkg::F_LO)) begin
                  f_ff <= pbosc_pkg::F_LO;
               end else if (fsh > 35'(f_hi)) begin
                  f_ff <= f_hi;
               end else begin
                  f_ff <= 34'(fsh);
               end
               state_ff <= ST_SMUL;
            end
            ST_SMUL: begin
               dp_ff <= 47'(dlt) * $signed({35'b0, pbosc_pkg::SMOOTH_Q16});
               state_ff <= ST_SUPD;
            end
            ST_SUPD: begin
               s_ff <= 34'(s_next);
               state_ff <= ST_DIVI;
            end
            ST_DIVI: begin
               state_ff <= ST_WINC;
            end
            ST_WINC: begin
               if (div_sts.done) begin
                  inc_ff <= div_q;
                  state_ff <= ST_BLEP;
               end
            end
            ST_BLEP: begin
               neg_ff <= (t >= dt);
               blep_ff <= '0;
               state_ff <= div_cmd.start ? ST_WBLEP : ST_SINE;
            end
            ST_WBLEP: begin
               if (div_sts.done) begin
                  x_ff <= div_q[15:0];
                  state_ff <= ST_SQ;
               end
            end
            ST_SQ: begin
               sq_ff <= 32'(x_ff) * 32'(x_ff);
               state_ff <= ST_BLEPV;
            end
            ST_BLEPV: begin
               blep_ff <= 18'(blep_in);
               state_ff <= ST_SINE;
            end
            ST_SINE: begin
               sine_ff <= sine_in;
               state_ff <= ST_MIX;
            end
            ST_MIX: begin
               mixp_ff <= 34'(diff) * $signed({21'b0, mix_eff});
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_data_ff <= out_in;
                  phase_ff <= phase_ff + inc_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign csr_ready = 1'b1;

`ifndef NO_ASSERTIONS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_EXP))
      else $error("accepted transfer did not start the sequencer");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_cmd.start |-> !div_sts.busy)
      else $error("divider started while busy");
   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($signed(rsp_data_ff) <= 16'sd20480
                        && $signed(rsp_data_ff) >= -16'sd20480))
      else $error("output sample outside saturation range");
   a_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == ST_WINC || state_ff == ST_WBLEP))
      else $error("divider finished with no one waiting");
`endif

endmodule

`default_nettype wire
